// File: rtl/ccs_pkg.sv
// Shared constants, types and codes of the copy request chunk splitter.
package ccs_pkg;

   localparam int ADDR_W       = 48;
   localparam int LEN_W        = 24;
   localparam int MAX_LEN      = 16384;
   localparam int LINE_BYTES   = 64;
   localparam int PAGE_BYTES   = 4096;
   localparam int MAX_RESULTS  = 64;
   localparam int CNT_W        = $clog2(MAX_RESULTS);
   localparam int THR_W        = 16;
   localparam int WARM_W       = 2;
   localparam int THR_RESET    = 1023;
   localparam int WARM_RESET   = 2;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_PLAIN  = 2'd0,
      KIND_PIECE  = 2'd1,
      KIND_LINES  = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CLS_PLAIN,
      CLS_REJECT,
      CLS_SPLIT
   } cls_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FRINGE,
      BK_BODY
   } back_state_type;

   typedef enum logic {
      REG_PLAIN_THRESHOLD = 1'b0,
      REG_WARMUP_COUNT    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [THR_W-1:0]  plain_threshold;
      logic [WARM_W-1:0] warmup_count;
      logic              warmup_load;
   } csr_type;

   typedef struct packed {
      logic [ADDR_W-1:0] dest;
      logic [ADDR_W-1:0] src;
      logic [LEN_W-1:0]  len;
      cls_type           cls;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/ccs_if.sv
// Valid/ready channel interfaces for copy requests and chunk results.
interface ccs_req_if;
   logic                          valid;
   logic                          ready;
   logic [ccs_pkg::ADDR_W-1:0]    dest_addr;
   logic [ccs_pkg::ADDR_W-1:0]    src_addr;
   logic [ccs_pkg::LEN_W-1:0]     length;

   modport source (output valid, dest_addr, src_addr, length, input ready);
   modport sink   (input valid, dest_addr, src_addr, length, output ready);
endinterface

interface ccs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ccs_pkg::ADDR_W-1:0]    chunk_dest;
   logic [ccs_pkg::ADDR_W-1:0]    chunk_src;
   logic [ccs_pkg::LEN_W-1:0]     chunk_len;
   logic [1:0]                    kind;
   logic                          last;

   modport source (output valid, chunk_dest, chunk_src, chunk_len, kind, last, input ready);
   modport sink   (input valid, chunk_dest, chunk_src, chunk_len, kind, last, output ready);
endinterface

// File: rtl/ccs_front.sv
// Front end: accepts copy requests, classifies them and tracks the warm-up.
module ccs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  ccs_pkg::csr_type          csr,
   ccs_req_if.sink                   req,
   input  ccs_pkg::queue_status_type qstat,
   output logic                      push,
   output ccs_pkg::job_type          job
);
   import ccs_pkg::*;

   logic [WARM_W-1:0] warmup_left_ff;
   logic [WARM_W-1:0] warmup_left_in;
   logic              is_plain;
   logic              is_long;
   logic              in_warmup;

   always_comb begin
      is_plain  = req.length <= LEN_W'(csr.plain_threshold);
      is_long   = req.length > LEN_W'(MAX_LEN);
      in_warmup = warmup_left_ff != '0;
      req.ready = !qstat.full;
      push      = req.valid && !qstat.full;
      job.dest  = req.dest_addr;
      job.src   = req.src_addr;
      job.len   = req.length;
      if (is_plain) begin
         job.cls = CLS_PLAIN;
      end else if (is_long) begin
         job.cls = CLS_REJECT;
      end else if (in_warmup) begin
         job.cls = CLS_PLAIN;
      end else begin
         job.cls = CLS_SPLIT;
      end
      warmup_left_in = warmup_left_ff;
      if (csr.warmup_load) begin
         warmup_left_in = csr.warmup_count;
      end else if (push && !is_plain && !is_long && in_warmup) begin
         warmup_left_in = warmup_left_ff - WARM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_left_ff <= WARM_W'(WARM_RESET);
      end else begin
         warmup_left_ff <= warmup_left_in;
      end
   end

endmodule

// File: rtl/ccs_queue.sv
// Short queue of classified requests between the front end and the back end.
module ccs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ccs_pkg::job_type          job_in,
   input  logic                      pop,
   output ccs_pkg::job_type          job_out,
   output ccs_pkg::queue_status_type qstat
);
   import ccs_pkg::*;

   job_type           ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      qstat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
      qstat.empty = count_ff == '0;
      job_out     = ent_ff[rd_ptr_ff];
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/ccs_back.sv
// Back end: fringe, page and line chunks, one per cycle while output is free.
module ccs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ccs_pkg::job_type          job,
   input  ccs_pkg::queue_status_type qstat,
   output logic                      pop,
   ccs_rsp_if.source                 rsp
);
   import ccs_pkg::*;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [ADDR_W-1:0] dest_ff;
   logic [ADDR_W-1:0] dest_in;
   logic [ADDR_W-1:0] src_ff;
   logic [ADDR_W-1:0] src_in;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [ADDR_W-1:0] out_dest_ff;
   logic [ADDR_W-1:0] out_dest_in;
   logic [ADDR_W-1:0] out_src_ff;
   logic [ADDR_W-1:0] out_src_in;
   logic [LEN_W-1:0]  out_len_ff;
   logic [LEN_W-1:0]  out_len_in;
   kind_type          out_kind_ff;
   kind_type          out_kind_in;
   logic              out_last_ff;
   logic              out_last_in;

   logic              out_free;
   logic [LEN_W-1:0]  line_off;
   logic [LEN_W-1:0]  fringe;
   logic [LEN_W-1:0]  fringe_len;
   logic [LEN_W-1:0]  soff;
   logic [LEN_W-1:0]  doff;
   logic [LEN_W-1:0]  page_min;
   logic [LEN_W-1:0]  piece_raw;
   logic [LEN_W-1:0]  piece;
   kind_type          piece_kind;
   logic              fringe_last;
   logic              piece_last;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.chunk_dest = out_dest_ff;
   assign rsp.chunk_src  = out_src_ff;
   assign rsp.chunk_len  = out_len_ff;
   assign rsp.kind       = out_kind_ff;
   assign rsp.last       = out_last_ff;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp.ready;
      line_off    = LEN_W'(dest_ff % LINE_BYTES);
      fringe      = LEN_W'(LINE_BYTES) - line_off;
      fringe_len  = (fringe < len_ff) ? fringe : len_ff;
      fringe_last = fringe_len == len_ff;
      soff        = LEN_W'(PAGE_BYTES) - LEN_W'(src_ff % PAGE_BYTES);
      doff        = LEN_W'(PAGE_BYTES) - LEN_W'(dest_ff % PAGE_BYTES);
      page_min    = (soff < doff) ? soff : doff;
      piece_raw   = (page_min < len_ff) ? page_min : len_ff;
      if (cnt_ff == CNT_W'(MAX_RESULTS - 1)) begin
         piece      = len_ff;
         piece_kind = KIND_PIECE;
      end else if (piece_raw < LEN_W'(LINE_BYTES)) begin
         piece      = (len_ff >= LEN_W'(LINE_BYTES)) ? LEN_W'(LINE_BYTES) : len_ff;
         piece_kind = KIND_PIECE;
      end else begin
         piece      = piece_raw - LEN_W'(piece_raw % LINE_BYTES);
         piece_kind = KIND_LINES;
      end
      piece_last = piece == len_ff;

      pop          = 1'b0;
      state_in     = state_ff;
      dest_in      = dest_ff;
      src_in       = src_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_dest_in  = out_dest_ff;
      out_src_in   = out_src_ff;
      out_len_in   = out_len_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty && out_free) begin
               pop = 1'b1;
               if (job.cls == CLS_SPLIT) begin
                  dest_in  = job.dest;
                  src_in   = job.src;
                  len_in   = job.len;
                  cnt_in   = '0;
                  state_in = BK_FRINGE;
               end else begin
                  rsp_valid_in = 1'b1;
                  out_dest_in  = job.dest;
                  out_src_in   = job.src;
                  out_len_in   = job.len;
                  out_kind_in  = (job.cls == CLS_REJECT) ? KIND_REJECT : KIND_PLAIN;
                  out_last_in  = 1'b1;
               end
            end
         end
         BK_FRINGE: begin
            if (line_off == '0) begin
               state_in = BK_BODY;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               out_dest_in  = dest_ff;
               out_src_in   = src_ff;
               out_len_in   = fringe_len;
               out_kind_in  = KIND_PIECE;
               out_last_in  = fringe_last;
               dest_in      = dest_ff + ADDR_W'(fringe_len);
               src_in       = src_ff + ADDR_W'(fringe_len);
               len_in       = len_ff - fringe_len;
               cnt_in       = CNT_W'(1);
               state_in     = fringe_last ? BK_IDLE : BK_BODY;
            end
         end
         BK_BODY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_dest_in  = dest_ff;
               out_src_in   = src_ff;
               out_len_in   = piece;
               out_kind_in  = piece_kind;
               out_last_in  = piece_last;
               dest_in      = dest_ff + ADDR_W'(piece);
               src_in       = src_ff + ADDR_W'(piece);
               len_in       = len_ff - piece;
               cnt_in       = cnt_ff + CNT_W'(1);
               state_in     = piece_last ? BK_IDLE : BK_BODY;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dest_ff     <= dest_in;
      src_ff      <= src_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      out_dest_ff <= out_dest_in;
      out_src_ff  <= out_src_in;
      out_len_ff  <= out_len_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/copy_request_chunk_splitter_unit.sv
// Top level of the copy request chunk splitter with its configuration registers.
// Each copy request gives one or more chunk items. A request no longer than
// plain_threshold, a long request during the warm-up, and a request above
// 16384 bytes (rejected) each give one item; the back end issues it in the
// cycle after taking the request from the two-entry queue. A split request is
// first loaded into the back end, which then issues one chunk per cycle while
// the output register is free, the line fringe included. When the destination
// is already line aligned, the fringe step issues nothing and passes on to the
// body chunks. The back end's chunk walk limits the throughput; the front end
// keeps accepting requests while the queue has room, and a chunk waiting in the
// output register stalls the back end until the result side takes it.
module copy_request_chunk_splitter_unit (
   input  logic                             clock,
   input  logic                             reset,
   ccs_req_if.sink                          req_chan,
   ccs_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ccs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ccs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ccs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import ccs_pkg::*;

   logic [THR_W-1:0]  thr_ff;
   logic [THR_W-1:0]  thr_in;
   logic [WARM_W-1:0] warm_ff;
   logic [WARM_W-1:0] warm_in;
   logic              csr_wr;
   reg_index_type     reg_index;
   csr_type           csr;
   queue_status_type  qstat;
   job_type           push_job;
   job_type           head_job;
   logic              push;
   logic              pop;

   assign csr_pready = 1'b1;

   always_comb begin
      csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
      reg_index = reg_index_type'(csr_paddr[2]);
      thr_in    = thr_ff;
      warm_in   = warm_ff;
      csr.warmup_load = 1'b0;
      case (reg_index)
         REG_PLAIN_THRESHOLD: begin
            csr_prdata = CSR_DATA_W'(thr_ff);
            if (csr_wr) begin
               thr_in = csr_pwdata[THR_W-1:0];
            end
         end
         REG_WARMUP_COUNT: begin
            csr_prdata = CSR_DATA_W'(warm_ff);
            if (csr_wr) begin
               warm_in         = csr_pwdata[WARM_W-1:0];
               csr.warmup_load = 1'b1;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
      csr.plain_threshold = thr_ff;
      csr.warmup_count    = warm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_W'(THR_RESET);
         warm_ff <= WARM_W'(WARM_RESET);
      end else begin
         thr_ff  <= thr_in;
         warm_ff <= warm_in;
      end
   end

   ccs_front u_front (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .req   (req_chan),
      .qstat (qstat),
      .push  (push),
      .job   (push_job)
   );

   ccs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (push_job),
      .pop     (pop),
      .job_out (head_job),
      .qstat   (qstat)
   );

   ccs_back u_back (
      .clock (clock),
      .reset (reset),
      .job   (head_job),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

`ifndef SYNTHESIS
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("Queue reports full and empty at once.");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("Item pushed into a full queue.");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("Item popped from an empty queue.");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.kind == KIND_PLAIN || rsp_chan.kind == KIND_REJECT)
      |-> rsp_chan.last)
      else $error("Plain or rejected item is not marked last.");
`endif

endmodule
